/* hw/rtl/srgb_pkg.sv */
// ----------------------------------------------------------------------------
// Serial RGB LED driver package
// Shared constants, command codes and types of the serial RGB LED driver.
// ----------------------------------------------------------------------------
`default_nettype none

package srgb_pkg;

  localparam int MaxLeds    = 1024;
  localparam int BitsPerLed = 24;
  localparam int QueueDepth = 2;

  localparam int ColourW   = 24;
  localparam int TickW     = 15;
  localparam int LedTotalW = 11;
  localparam int OpW       = 3;
  localparam int IndexW    = 10;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 15;

  localparam int LedIdxW = (MaxLeds > 1) ? $clog2(MaxLeds) : 1;
  localparam int CountW  = $clog2(MaxLeds + 1);
  localparam int BitPtrW = $clog2(BitsPerLed);

  localparam logic [OpW-1:0] OpWrite   = 3'd0;
  localparam logic [OpW-1:0] OpRead    = 3'd1;
  localparam logic [OpW-1:0] OpFill    = 3'd2;
  localparam logic [OpW-1:0] OpClear   = 3'd3;
  localparam logic [OpW-1:0] OpRefresh = 3'd4;
  localparam logic [OpW-1:0] OpTick    = 3'd5;

  localparam logic [CfgIdxW-1:0] CfgLedTotal     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOneHighTicks  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgOneLowTicks   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgZeroHighTicks = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgZeroLowTicks  = 3'd4;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_FILL,
    CMD_CLEAR,
    CMD_REFRESH,
    CMD_TICK,
    CMD_BAD
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_LOAD
  } back_state_e;

  typedef struct packed {
    cmd_e               cmd;
    logic               in_range;
    logic [IndexW-1:0]  led_index;
    logic [ColourW-1:0] colour;
  } cmd_t;

  typedef struct packed {
    logic [CountW-1:0] leds_used;
    logic [TickW-1:0]  one_high;
    logic [TickW-1:0]  one_low;
    logic [TickW-1:0]  zero_high;
    logic [TickW-1:0]  zero_low;
  } cfg_t;

  typedef struct packed {
    logic               line_level;
    logic [ColourW-1:0] read_colour;
    logic               accepted;
    logic               busy_res;
  } res_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  function automatic logic [TickW-1:0] phase_len(input logic [TickW-1:0] ticks);
    return (ticks == '0) ? TickW'(1) : ticks;
  endfunction

  function automatic logic led_bit(input logic [ColourW-1:0] word,
                                   input logic [BitPtrW-1:0] bit_ptr);
    int   pos;
    logic b;
    pos = BitsPerLed - 1 - int'(bit_ptr);
    b   = 1'b0;
    if (pos >= 0 && pos < ColourW) begin
      b = word[pos];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/srgb_cmd_if.sv */
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command transaction to the driver.
// ----------------------------------------------------------------------------
`default_nettype none

interface srgb_cmd_if import srgb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     operation;
  logic [IndexW-1:0]  led_index;
  logic [ColourW-1:0] colour_word;

  modport source(output valid, output operation, output led_index, output colour_word,
                 input ready);
  modport sink(input valid, input operation, input led_index, input colour_word,
               output ready);
endinterface

`default_nettype wire

/* hw/rtl/srgb_res_if.sv */
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result transaction from the driver.
// ----------------------------------------------------------------------------
`default_nettype none

interface srgb_res_if import srgb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               line_level;
  logic [ColourW-1:0] read_colour;
  logic               accepted;
  logic               busy_res;

  modport source(output valid, output line_level, output read_colour, output accepted,
                 output busy_res, input ready);
  modport sink(input valid, input line_level, input read_colour, input accepted,
               input busy_res, output ready);
endinterface

`default_nettype wire

/* hw/rtl/srgb_front.sv */
// ----------------------------------------------------------------------------
// Command front end
// Accepts command transactions, decodes the operation and checks the index.
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_front import srgb_pkg::*; (
  srgb_cmd_if.sink   cmd_i,
  input  cfg_t       cfg_i,
  input  back_stat_t stat_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  assign cmd_i.ready = !full_i && !stat_i.init_busy;
  assign push_o      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    unique case (cmd_i.operation)
      OpWrite:   cmd_o.cmd = CMD_WRITE;
      OpRead:    cmd_o.cmd = CMD_READ;
      OpFill:    cmd_o.cmd = CMD_FILL;
      OpClear:   cmd_o.cmd = CMD_CLEAR;
      OpRefresh: cmd_o.cmd = CMD_REFRESH;
      OpTick:    cmd_o.cmd = CMD_TICK;
      default:   cmd_o.cmd = CMD_BAD;
    endcase
    cmd_o.in_range  = int'(cmd_i.led_index) < int'(cfg_i.leds_used);
    cmd_o.led_index = cmd_i.led_index;
    cmd_o.colour    = cmd_i.colour_word;
  end

endmodule

`default_nettype wire

/* hw/rtl/srgb_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_cmd_fifo import srgb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srgb_back.sv */
// ----------------------------------------------------------------------------
// Command back end
// Colour store, store sweeps, pulse timing of the serial line and results.
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_back import srgb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        pop_o,
  output back_stat_t  stat_o,
  srgb_res_if.source  res_o
);

  back_state_e state_q, state_d;

  logic [ColourW-1:0] store_q [MaxLeds];
  logic               mem_we;
  logic [LedIdxW-1:0] mem_waddr;
  logic [ColourW-1:0] mem_wdata;
  logic               mem_re;
  logic [LedIdxW-1:0] mem_raddr;
  logic [ColourW-1:0] mem_rdata_q;

  logic               sending_q, sending_d;
  logic [LedIdxW-1:0] led_ptr_q, led_ptr_d;
  logic [BitPtrW-1:0] bit_ptr_q, bit_ptr_d;
  logic               low_q, low_d;
  logic [TickW-1:0]   ticks_q, ticks_d;
  logic [ColourW-1:0] shift_q, shift_d;
  logic [CountW-1:0]  sweep_q, sweep_d;
  logic [ColourW-1:0] fill_q, fill_d;
  logic               clear_q, clear_d;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;

  logic               slot_free;
  logic               cur_bit;
  logic               last_bit;
  logic [CountW-1:0]  next_led;
  logic               led_end;
  logic               phase_end;
  logic               tick_next_led;
  logic               sweep_done;
  logic               count_zero;
  logic               emit;
  res_t               emit_res;

  assign slot_free     = !out_valid_q || res_o.ready;
  assign pop_o         = (state_q == ST_IDLE) && q_valid_i && slot_free;
  assign stat_o.init_busy = state_q == ST_INIT;

  assign cur_bit       = led_bit(shift_q, bit_ptr_q);
  assign last_bit      = bit_ptr_q == BitPtrW'(BitsPerLed - 1);
  assign next_led      = CountW'(led_ptr_q) + CountW'(1);
  assign led_end       = next_led >= cfg_i.leds_used;
  assign phase_end     = !(ticks_q > TickW'(1));
  assign tick_next_led = sending_q && phase_end && low_q && last_bit && !led_end;
  assign sweep_done    = sweep_q == cfg_i.leds_used;
  assign count_zero    = cfg_i.leds_used == '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sweep_q == CountW'(MaxLeds - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_o) begin
          unique case (q_cmd_i.cmd)
            CMD_READ: begin
              if (q_cmd_i.in_range) begin
                state_d = ST_READ;
              end
            end
            CMD_FILL, CMD_CLEAR: begin
              if (!sending_q) begin
                state_d = ST_SWEEP;
              end
            end
            CMD_REFRESH: begin
              if (!sending_q && !count_zero) begin
                state_d = ST_LOAD;
              end
            end
            CMD_TICK: begin
              if (tick_next_led) begin
                state_d = ST_LOAD;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_SWEEP: begin
        if (sweep_done) begin
          state_d = (clear_q && !count_zero) ? ST_LOAD : ST_IDLE;
        end
      end
      ST_LOAD: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sending_d   = sending_q;
    led_ptr_d   = led_ptr_q;
    bit_ptr_d   = bit_ptr_q;
    low_d       = low_q;
    ticks_d     = ticks_q;
    shift_d     = shift_q;
    sweep_d     = sweep_q;
    fill_d      = fill_q;
    clear_d     = clear_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    emit        = 1'b0;
    emit_res    = '0;
    out_valid_d = out_valid_q && !res_o.ready;
    res_d       = res_q;

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q[LedIdxW-1:0];
        sweep_d   = (sweep_q == CountW'(MaxLeds - 1)) ? '0 : sweep_q + CountW'(1);
      end
      ST_IDLE: begin
        if (pop_o) begin
          emit = 1'b1;
          unique case (q_cmd_i.cmd)
            CMD_WRITE: begin
              if (!sending_q && q_cmd_i.in_range) begin
                mem_we            = 1'b1;
                mem_waddr         = LedIdxW'(q_cmd_i.led_index);
                mem_wdata         = q_cmd_i.colour;
                emit_res.accepted = 1'b1;
              end
            end
            CMD_READ: begin
              if (q_cmd_i.in_range) begin
                mem_re    = 1'b1;
                mem_raddr = LedIdxW'(q_cmd_i.led_index);
                emit      = 1'b0;
              end
            end
            CMD_FILL, CMD_CLEAR: begin
              if (!sending_q) begin
                sweep_d = '0;
                fill_d  = (q_cmd_i.cmd == CMD_FILL) ? q_cmd_i.colour : '0;
                clear_d = q_cmd_i.cmd == CMD_CLEAR;
                emit    = 1'b0;
              end
            end
            CMD_REFRESH: begin
              if (!sending_q) begin
                emit_res.accepted = 1'b1;
                if (!count_zero) begin
                  sending_d = 1'b1;
                  led_ptr_d = '0;
                  bit_ptr_d = '0;
                  low_d     = 1'b0;
                  mem_re    = 1'b1;
                end
              end
            end
            CMD_TICK: begin
              emit_res.accepted = 1'b1;
              if (sending_q) begin
                if (!phase_end) begin
                  ticks_d = ticks_q - TickW'(1);
                end else if (!low_q) begin
                  low_d   = 1'b1;
                  ticks_d = phase_len(cur_bit ? cfg_i.one_low : cfg_i.zero_low);
                end else if (last_bit) begin
                  if (led_end) begin
                    sending_d = 1'b0;
                    low_d     = 1'b0;
                    ticks_d   = '0;
                    bit_ptr_d = '0;
                    led_ptr_d = '0;
                  end else begin
                    led_ptr_d = next_led[LedIdxW-1:0];
                    bit_ptr_d = '0;
                    low_d     = 1'b0;
                    mem_re    = 1'b1;
                    mem_raddr = next_led[LedIdxW-1:0];
                  end
                end else begin
                  bit_ptr_d = bit_ptr_q + BitPtrW'(1);
                  low_d     = 1'b0;
                  ticks_d   = phase_len(led_bit(shift_q, bit_ptr_q + BitPtrW'(1)) ?
                                        cfg_i.one_high : cfg_i.zero_high);
                end
              end
            end
            default: emit_res.accepted = 1'b0;
          endcase
          if (q_cmd_i.cmd == CMD_TICK) begin
            emit_res.line_level = sending_q && !low_q;
          end else begin
            emit_res.line_level = sending_d && !low_d;
          end
          emit_res.busy_res = sending_d;
        end
      end
      ST_READ: begin
        emit                 = 1'b1;
        emit_res.read_colour = mem_rdata_q;
        emit_res.accepted    = 1'b1;
        emit_res.line_level  = sending_q && !low_q;
        emit_res.busy_res    = sending_q;
      end
      ST_SWEEP: begin
        if (sweep_done) begin
          emit              = 1'b1;
          emit_res.accepted = 1'b1;
          if (clear_q && !count_zero) begin
            sending_d = 1'b1;
            led_ptr_d = '0;
            bit_ptr_d = '0;
            low_d     = 1'b0;
            mem_re    = 1'b1;
          end
          emit_res.line_level = sending_d && !low_d;
          emit_res.busy_res   = sending_d;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = sweep_q[LedIdxW-1:0];
          mem_wdata = fill_q;
          sweep_d   = sweep_q + CountW'(1);
        end
      end
      ST_LOAD: begin
        shift_d = mem_rdata_q;
        low_d   = 1'b0;
        ticks_d = phase_len(led_bit(mem_rdata_q, '0) ? cfg_i.one_high : cfg_i.zero_high);
      end
      default: emit = 1'b0;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
      res_d       = emit_res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= store_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sending_q   <= 1'b0;
      led_ptr_q   <= '0;
      bit_ptr_q   <= '0;
      low_q       <= 1'b0;
      ticks_q     <= '0;
      sweep_q     <= '0;
      clear_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sending_q   <= sending_d;
      led_ptr_q   <= led_ptr_d;
      bit_ptr_q   <= bit_ptr_d;
      low_q       <= low_d;
      ticks_q     <= ticks_d;
      sweep_q     <= sweep_d;
      clear_q     <= clear_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    fill_q  <= fill_d;
    res_q   <= res_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.line_level  = res_q.line_level;
  assign res_o.read_colour = res_q.read_colour;
  assign res_o.accepted    = res_q.accepted;
  assign res_o.busy_res    = res_q.busy_res;

  a_idle_line_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (ticks_q == '0 && !low_q && bit_ptr_q == '0))
    else $error("Line timing state not cleared while no refresh is running.");

  a_phase_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && sending_q) |-> ticks_q != '0)
    else $error("Active pulse phase has no ticks left.");

  a_bit_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(bit_ptr_q) < BitsPerLed)
    else $error("Bit pointer beyond the last bit of an LED.");

  a_load_while_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> sending_q)
    else $error("LED word loaded while no refresh is running.");

endmodule

`default_nettype wire

/* hw/rtl/serial_rgb_led_pulse_driver.sv */
// ----------------------------------------------------------------------------
// Serial RGB LED pulse driver
// Colour store and single-wire pulse encoder for a chain of RGB LEDs.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024-entry colour store, one entry per
// cycle, and accepts no command transaction until the clear is done. Writes,
// refused commands and ticks within an LED complete in the idle state. A read
// passes through the read state because of the registered store read port.
// Fill and clear sweep the store one entry per cycle in the sweep state. A
// refresh or clear with a nonzero LED count, and a tick that moves to the next
// LED, pass through the load state to take the next colour word from the
// store. Each command yields exactly one result transaction, held in an output
// register so that the next command can be taken while it waits.
`default_nettype none

module serial_rgb_led_pulse_driver import srgb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  srgb_cmd_if.sink            cmd_i,
  srgb_res_if.source          res_o
);

  logic [LedTotalW-1:0] led_total_q;
  logic [TickW-1:0]     one_high_q;
  logic [TickW-1:0]     one_low_q;
  logic [TickW-1:0]     zero_high_q;
  logic [TickW-1:0]     zero_low_q;

  cfg_t       cfg;
  back_stat_t stat;
  logic       push;
  cmd_t       push_cmd;
  logic       full;
  logic       pop;
  logic       q_valid;
  cmd_t       q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_total_q <= '0;
      one_high_q  <= TickW'(64);
      one_low_q   <= TickW'(36);
      zero_high_q <= TickW'(32);
      zero_low_q  <= TickW'(68);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgLedTotal:      led_total_q <= cfg_data_i[LedTotalW-1:0];
        CfgOneHighTicks:  one_high_q  <= cfg_data_i[TickW-1:0];
        CfgOneLowTicks:   one_low_q   <= cfg_data_i[TickW-1:0];
        CfgZeroHighTicks: zero_high_q <= cfg_data_i[TickW-1:0];
        CfgZeroLowTicks:  zero_low_q  <= cfg_data_i[TickW-1:0];
        default:          led_total_q <= led_total_q;
      endcase
    end
  end

  always_comb begin
    if (int'(led_total_q) >= MaxLeds) begin
      cfg.leds_used = CountW'(MaxLeds);
    end else begin
      cfg.leds_used = CountW'(led_total_q);
    end
    cfg.one_high  = one_high_q;
    cfg.one_low   = one_low_q;
    cfg.zero_high = zero_high_q;
    cfg.zero_low  = zero_low_q;
  end

  srgb_front u_front (
    .cmd_i  (cmd_i),
    .cfg_i  (cfg),
    .stat_i (stat),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  srgb_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  srgb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .stat_o    (stat),
    .res_o     (res_o)
  );

endmodule

`default_nettype wire
